[sv/kvp_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package kvp_pkg;

   // result kinds
   localparam logic [1:0] KIND_KEY     = 2'd0;
   localparam logic [1:0] KIND_VALUE   = 2'd1;
   localparam logic [1:0] KIND_SUMMARY = 2'd2;

   // command codes
   localparam logic [2:0] CMD_SET    = 3'd0;
   localparam logic [2:0] CMD_GET    = 3'd1;
   localparam logic [2:0] CMD_DELETE = 3'd2;
   localparam logic [2:0] CMD_EXPIRE = 3'd3;
   localparam logic [2:0] CMD_OTHER  = 3'd4;

   localparam int NUM_NAMES = 4;
   localparam int NAME_MAX  = 6;

   typedef logic [7:0] name_row_type [NAME_MAX];

   localparam name_row_type NAME_TEXT [NUM_NAMES] = '{
      '{8'h53, 8'h45, 8'h54, 8'h00, 8'h00, 8'h00},
      '{8'h47, 8'h45, 8'h54, 8'h00, 8'h00, 8'h00},
      '{8'h44, 8'h45, 8'h4c, 8'h45, 8'h54, 8'h45},
      '{8'h45, 8'h58, 8'h50, 8'h49, 8'h52, 8'h45}
   };

   localparam logic [7:0] NAME_LEN [NUM_NAMES] = '{8'd3, 8'd3, 8'd6, 8'd6};

   typedef struct packed {
      logic [1:0]  item_kind;
      logic [7:0]  payload_byte;
      logic [2:0]  command_code;
      logic [7:0]  key_length;
      logic        value_present;
      logic [15:0] value_length;
      logic [31:0] time_to_live;
   } rsp_type;

endpackage

`default_nettype wire

[sv/kvp_cmd_match.sv]
`timescale 1ns / 1ps
`default_nettype none

module kvp_cmd_match (
   input  wire logic [3:0] cand,
   input  wire logic [7:0] pos,
   input  wire logic [7:0] data,
   output logic      [3:0] cand_next,
   output logic      [2:0] code
);
   import kvp_pkg::*;

   always_comb begin
      for (int i = 0; i < NUM_NAMES; i++) begin
         cand_next[i] = cand[i] && (pos < NAME_LEN[i]) &&
                        (NAME_TEXT[i][pos[2:0]] == data);
      end
   end

   // first surviving name whose length matches exactly
   always_comb begin
      code = CMD_OTHER;
      priority if (cand[0] && pos == NAME_LEN[0]) code = CMD_SET;
      else if (cand[1] && pos == NAME_LEN[1]) code = CMD_GET;
      else if (cand[2] && pos == NAME_LEN[2]) code = CMD_DELETE;
      else if (cand[3] && pos == NAME_LEN[3]) code = CMD_EXPIRE;
      else code = CMD_OTHER;
   end

endmodule

`default_nettype wire

[sv/kvp_parser.sv]
`timescale 1ns / 1ps
`default_nettype none

module kvp_parser (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              step,
   input  wire logic [7:0]        data_byte,
   input  wire logic              start_of_message,
   output logic                   res_valid,
   output kvp_pkg::rsp_type       res
);
   import kvp_pkg::*;

   localparam logic [3:0] PH_CMD_LEN  = 4'd0;
   localparam logic [3:0] PH_CMD      = 4'd1;
   localparam logic [3:0] PH_KEY_LEN  = 4'd2;
   localparam logic [3:0] PH_KEY      = 4'd3;
   localparam logic [3:0] PH_VAL_FLAG = 4'd4;
   localparam logic [3:0] PH_VLEN_HI  = 4'd5;
   localparam logic [3:0] PH_VLEN_LO  = 4'd6;
   localparam logic [3:0] PH_VAL      = 4'd7;
   localparam logic [3:0] PH_TTL_FLAG = 4'd8;
   localparam logic [3:0] PH_TTL      = 4'd9;
   localparam logic [3:0] PH_DONE     = 4'd10;

   logic [3:0]  phase_ff, phase_in;
   logic [15:0] remain_ff, remain_in;
   logic [3:0]  cand_ff, cand_in;
   logic [7:0]  pos_ff, pos_in;
   logic        cmd_zero_ff, cmd_zero_in;
   logic        fld_zero_ff, fld_zero_in;
   logic [7:0]  key_cnt_ff, key_cnt_in;
   logic        vflag_ff, vflag_in;
   logic [15:0] val_cnt_ff, val_cnt_in;
   logic [31:0] ttl_ff, ttl_in;
   logic [7:0]  len_hi_ff, len_hi_in;

   logic [3:0]  cand_next;
   logic [2:0]  code;
   logic        last_byte;
   logic [15:0] vlen_full;

   kvp_cmd_match u_match (
      .cand      (cand_ff),
      .pos       (pos_ff),
      .data      (data_byte),
      .cand_next (cand_next),
      .code      (code)
   );

   assign last_byte = (remain_ff == 16'd1);
   assign vlen_full = {len_hi_ff, data_byte};

   always_comb begin
      phase_in    = phase_ff;
      remain_in   = remain_ff;
      cand_in     = cand_ff;
      pos_in      = pos_ff;
      cmd_zero_in = cmd_zero_ff;
      fld_zero_in = fld_zero_ff;
      key_cnt_in  = key_cnt_ff;
      vflag_in    = vflag_ff;
      val_cnt_in  = val_cnt_ff;
      ttl_in      = ttl_ff;
      len_hi_in   = len_hi_ff;
      res_valid   = 1'b0;
      res         = '0;

      if (step) begin
         if (start_of_message || phase_ff == PH_CMD_LEN) begin
            remain_in   = {8'd0, data_byte};
            cand_in     = 4'hf;
            pos_in      = 8'd0;
            cmd_zero_in = 1'b0;
            fld_zero_in = 1'b0;
            key_cnt_in  = 8'd0;
            vflag_in    = 1'b0;
            val_cnt_in  = 16'd0;
            ttl_in      = 32'd0;
            len_hi_in   = 8'd0;
            phase_in    = (data_byte != 8'd0) ? PH_CMD : PH_KEY_LEN;
         end else begin
            unique case (phase_ff)
               PH_CMD: begin
                  if (cmd_zero_ff || data_byte == 8'd0) begin
                     cmd_zero_in = 1'b1;
                  end else begin
                     cand_in = cand_next;
                     if (pos_ff != 8'hff) pos_in = pos_ff + 8'd1;
                  end
                  remain_in = remain_ff - 16'd1;
                  if (last_byte) phase_in = PH_KEY_LEN;
               end
               PH_KEY_LEN: begin
                  remain_in   = {8'd0, data_byte};
                  fld_zero_in = 1'b0;
                  phase_in    = (data_byte != 8'd0) ? PH_KEY : PH_VAL_FLAG;
               end
               PH_KEY: begin
                  if (!fld_zero_ff && data_byte != 8'd0) begin
                     res_valid        = 1'b1;
                     res.item_kind    = KIND_KEY;
                     res.payload_byte = data_byte;
                     key_cnt_in       = key_cnt_ff + 8'd1;
                  end else begin
                     fld_zero_in = 1'b1;
                  end
                  remain_in = remain_ff - 16'd1;
                  if (last_byte) phase_in = PH_VAL_FLAG;
               end
               PH_VAL_FLAG: begin
                  vflag_in = (data_byte == 8'd1);
                  phase_in = (data_byte == 8'd1) ? PH_VLEN_HI : PH_TTL_FLAG;
               end
               PH_VLEN_HI: begin
                  len_hi_in = data_byte;
                  phase_in  = PH_VLEN_LO;
               end
               PH_VLEN_LO: begin
                  remain_in   = vlen_full;
                  fld_zero_in = 1'b0;
                  phase_in    = (vlen_full != 16'd0) ? PH_VAL : PH_TTL_FLAG;
               end
               PH_VAL: begin
                  if (!fld_zero_ff && data_byte != 8'd0) begin
                     res_valid        = 1'b1;
                     res.item_kind    = KIND_VALUE;
                     res.payload_byte = data_byte;
                     val_cnt_in       = val_cnt_ff + 16'd1;
                  end else begin
                     fld_zero_in = 1'b1;
                  end
                  remain_in = remain_ff - 16'd1;
                  if (last_byte) phase_in = PH_TTL_FLAG;
               end
               PH_TTL_FLAG: begin
                  ttl_in = 32'd0;
                  if (data_byte == 8'd1) begin
                     remain_in = 16'd4;
                     phase_in  = PH_TTL;
                  end else begin
                     res_valid         = 1'b1;
                     res.item_kind     = KIND_SUMMARY;
                     res.command_code  = code;
                     res.key_length    = key_cnt_ff;
                     res.value_present = vflag_ff;
                     res.value_length  = vflag_ff ? val_cnt_ff : 16'd0;
                     res.time_to_live  = 32'd0;
                     phase_in          = PH_DONE;
                  end
               end
               PH_TTL: begin
                  ttl_in    = {ttl_ff[23:0], data_byte};
                  remain_in = remain_ff - 16'd1;
                  if (last_byte) begin
                     res_valid         = 1'b1;
                     res.item_kind     = KIND_SUMMARY;
                     res.command_code  = code;
                     res.key_length    = key_cnt_ff;
                     res.value_present = vflag_ff;
                     res.value_length  = vflag_ff ? val_cnt_ff : 16'd0;
                     res.time_to_live  = {ttl_ff[23:0], data_byte};
                     phase_in          = PH_DONE;
                  end
               end
               default: begin
                  phase_in = PH_DONE;
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_CMD_LEN;
         remain_ff   <= 16'd0;
         cand_ff     <= 4'd0;
         pos_ff      <= 8'd0;
         cmd_zero_ff <= 1'b0;
         fld_zero_ff <= 1'b0;
         key_cnt_ff  <= 8'd0;
         vflag_ff    <= 1'b0;
         val_cnt_ff  <= 16'd0;
         ttl_ff      <= 32'd0;
         len_hi_ff   <= 8'd0;
      end else begin
         phase_ff    <= phase_in;
         remain_ff   <= remain_in;
         cand_ff     <= cand_in;
         pos_ff      <= pos_in;
         cmd_zero_ff <= cmd_zero_in;
         fld_zero_ff <= fld_zero_in;
         key_cnt_ff  <= key_cnt_in;
         vflag_ff    <= vflag_in;
         val_cnt_ff  <= val_cnt_in;
         ttl_ff      <= ttl_in;
         len_hi_ff   <= len_hi_in;
      end
   end

endmodule

`default_nettype wire

[sv/kvp_rsp_reg.sv]
`timescale 1ns / 1ps
`default_nettype none

module kvp_rsp_reg (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              load,
   input  wire logic              in_valid,
   input  wire kvp_pkg::rsp_type  in_data,
   output logic                   can_load,
   output logic                   out_valid,
   output kvp_pkg::rsp_type       out_data,
   input  wire logic              out_ready
);
   import kvp_pkg::*;

   logic    valid_ff, valid_in;
   rsp_type data_ff;

   // register frees up in the same cycle it is drained
   assign can_load = !valid_ff || out_ready;

   always_comb begin
      valid_in = valid_ff;
      if (valid_ff && out_ready) valid_in = 1'b0;
      if (load && in_valid) valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) valid_ff <= 1'b0;
      else       valid_ff <= valid_in;
   end

   always_ff @(posedge clock) begin
      if (load && in_valid) data_ff <= in_data;
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

`default_nettype wire

[sv/kv_request_frame_parser_core.sv]
`timescale 1ns / 1ps
`default_nettype none
// latency: a result is valid on rsp_ the cycle after its request is accepted
// throughput: one request byte per cycle, held only by back-pressure on the
//    single result register ahead of rsp_
// reset: synchronous, clears the parse state and the result valid; the first
//    byte after reset is taken as a command length

module kv_request_frame_parser_core (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [7:0]  req_data_byte,
   input  wire logic        req_start_of_message,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [1:0]       rsp_item_kind,
   output logic [7:0]       rsp_payload_byte,
   output logic [2:0]       rsp_command_code,
   output logic [7:0]       rsp_key_length,
   output logic             rsp_value_present,
   output logic [15:0]      rsp_value_length,
   output logic [31:0]      rsp_time_to_live
);
   import kvp_pkg::*;

   logic    step;
   logic    res_valid;
   rsp_type res;
   rsp_type out_data;

   assign step = req_valid && req_ready;

   kvp_parser u_parser (
      .clock            (clock),
      .reset            (reset),
      .step             (step),
      .data_byte        (req_data_byte),
      .start_of_message (req_start_of_message),
      .res_valid        (res_valid),
      .res              (res)
   );

   kvp_rsp_reg u_rsp (
      .clock     (clock),
      .reset     (reset),
      .load      (step),
      .in_valid  (res_valid),
      .in_data   (res),
      .can_load  (req_ready),
      .out_valid (rsp_valid),
      .out_data  (out_data),
      .out_ready (rsp_ready)
   );

   assign rsp_item_kind     = out_data.item_kind;
   assign rsp_payload_byte  = out_data.payload_byte;
   assign rsp_command_code  = out_data.command_code;
   assign rsp_key_length    = out_data.key_length;
   assign rsp_value_present = out_data.value_present;
   assign rsp_value_length  = out_data.value_length;
   assign rsp_time_to_live  = out_data.time_to_live;

endmodule

`default_nettype wire

[sv/kvp_checker.sv]
`timescale 1ns / 1ps
`default_nettype none

module kvp_checker (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   input  wire logic        req_ready,
   input  wire logic        rsp_valid,
   input  wire logic        rsp_ready,
   input  wire logic [1:0]  rsp_item_kind,
   input  wire logic [7:0]  rsp_payload_byte,
   input  wire logic [2:0]  rsp_command_code,
   input  wire logic [7:0]  rsp_key_length,
   input  wire logic        rsp_value_present,
   input  wire logic [15:0] rsp_value_length,
   input  wire logic [31:0] rsp_time_to_live
);
   import kvp_pkg::*;

   // nothing is pending right after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_item_kind) &&
      $stable(rsp_payload_byte) && $stable(rsp_time_to_live))
      else $error("stalled result changed");

   // a stalled result blocks new requests
   a_ready_stall: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |-> !req_ready)
      else $error("request taken while result stalled");

   a_data_item_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_item_kind != KIND_SUMMARY |->
      rsp_payload_byte != 8'd0 && rsp_command_code == CMD_SET &&
      rsp_key_length == 8'd0 && !rsp_value_present &&
      rsp_value_length == 16'd0 && rsp_time_to_live == 32'd0)
      else $error("key or value item carries summary fields");

   a_summary_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_item_kind == KIND_SUMMARY |->
      rsp_payload_byte == 8'd0 && rsp_command_code <= CMD_OTHER &&
      (rsp_value_present || rsp_value_length == 16'd0))
      else $error("malformed summary item");

endmodule

bind kv_request_frame_parser_core kvp_checker u_kvp_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_valid),
   .req_ready         (req_ready),
   .rsp_valid         (rsp_valid),
   .rsp_ready         (rsp_ready),
   .rsp_item_kind     (rsp_item_kind),
   .rsp_payload_byte  (rsp_payload_byte),
   .rsp_command_code  (rsp_command_code),
   .rsp_key_length    (rsp_key_length),
   .rsp_value_present (rsp_value_present),
   .rsp_value_length  (rsp_value_length),
   .rsp_time_to_live  (rsp_time_to_live)
);

`default_nettype wire

[tb/sv/tb_kv_request_frame_parser_core.sv]
`timescale 1ns / 1ps

module tb_kv_request_frame_parser_core;
   import kvp_pkg::*;

   localparam int BYTE_TARGET    = 950;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int HOLD_CYCLES    = 300;
   localparam int MAX_REPORTS    = 10;

   typedef enum logic [3:0] {
      AT_CMD_LEN, AT_CMD, AT_KEY_LEN, AT_KEY, AT_VAL_FLAG, AT_VLEN_HI,
      AT_VLEN_LO, AT_VAL, AT_TTL_FLAG, AT_TTL, AT_DONE
   } parse_step_type;

   class frame_parse_tracker;
      parse_step_type step;
      logic [15:0] remaining;
      logic [63:0] cmd_word;
      int          cmd_count;
      bit          cmd_cut;
      bit          field_cut;
      bit          has_value;
      logic [7:0]  key_count;
      logic [7:0]  len_hi;
      logic [15:0] value_count;
      logic [31:0] ttl_bytes;
      rsp_type     due_items[$];
      int          error_count;

      function new();
         clear_message();
         step = AT_CMD_LEN;
         remaining = '0;
         cmd_count = 0;
         error_count = 0;
      endfunction

      function void clear_message();
         cmd_word = '0;
         cmd_count = 0;
         cmd_cut = 1'b0;
         field_cut = 1'b0;
         has_value = 1'b0;
         key_count = '0;
         len_hi = '0;
         value_count = '0;
         ttl_bytes = '0;
      endfunction

      function void push_summary();
         rsp_type item;
         item = '0;
         item.item_kind = KIND_SUMMARY;
         // only the bytes kept before a zero count, and the length must be exact
         if (cmd_count == 3 && cmd_word[23:0] == "SET")
            item.command_code = CMD_SET;
         else if (cmd_count == 3 && cmd_word[23:0] == "GET")
            item.command_code = CMD_GET;
         else if (cmd_count == 6 && cmd_word[47:0] == "DELETE")
            item.command_code = CMD_DELETE;
         else if (cmd_count == 6 && cmd_word[47:0] == "EXPIRE")
            item.command_code = CMD_EXPIRE;
         else
            item.command_code = CMD_OTHER;
         item.key_length = key_count;
         item.value_present = has_value;
         item.value_length = has_value ? value_count : 16'd0;
         item.time_to_live = ttl_bytes;
         due_items.push_back(item);
         step = AT_DONE;
      endfunction

      function void take_request_byte(logic [7:0] b, logic som);
         rsp_type item;
         item = '0;
         if (som || step == AT_CMD_LEN) begin
            clear_message();
            remaining = {8'd0, b};
            step = (b != 8'd0) ? AT_CMD : AT_KEY_LEN;
            return;
         end
         case (step)
            AT_CMD: begin
               if (cmd_cut || b == 8'd0) begin
                  cmd_cut = 1'b1;
               end else begin
                  cmd_word = {cmd_word[55:0], b};
                  cmd_count++;
               end
               remaining--;
               if (remaining == 16'd0) step = AT_KEY_LEN;
            end
            AT_KEY_LEN: begin
               remaining = {8'd0, b};
               field_cut = 1'b0;
               step = (b != 8'd0) ? AT_KEY : AT_VAL_FLAG;
            end
            AT_KEY: begin
               if (!field_cut && b != 8'd0) begin
                  item.item_kind = KIND_KEY;
                  item.payload_byte = b;
                  due_items.push_back(item);
                  key_count++;
               end else begin
                  field_cut = 1'b1;
               end
               remaining--;
               if (remaining == 16'd0) step = AT_VAL_FLAG;
            end
            AT_VAL_FLAG: begin
               has_value = (b == 8'd1);
               step = has_value ? AT_VLEN_HI : AT_TTL_FLAG;
            end
            AT_VLEN_HI: begin
               len_hi = b;
               step = AT_VLEN_LO;
            end
            AT_VLEN_LO: begin
               remaining = {len_hi, b};
               field_cut = 1'b0;
               step = (remaining != 16'd0) ? AT_VAL : AT_TTL_FLAG;
            end
            AT_VAL: begin
               if (!field_cut && b != 8'd0) begin
                  item.item_kind = KIND_VALUE;
                  item.payload_byte = b;
                  due_items.push_back(item);
                  value_count++;
               end else begin
                  field_cut = 1'b1;
               end
               remaining--;
               if (remaining == 16'd0) step = AT_TTL_FLAG;
            end
            AT_TTL_FLAG: begin
               ttl_bytes = '0;
               if (b == 8'd1) begin
                  remaining = 16'd4;
                  step = AT_TTL;
               end else begin
                  push_summary();
               end
            end
            AT_TTL: begin
               ttl_bytes = {ttl_bytes[23:0], b};
               remaining--;
               if (remaining == 16'd0) push_summary();
            end
            default: step = AT_DONE;
         endcase
      endfunction

      function string describe(rsp_type r);
         return $sformatf("kind %0d byte %02h cmd %0d klen %0d vpres %0d vlen %0d ttl %08h",
                          r.item_kind, r.payload_byte, r.command_code, r.key_length,
                          r.value_present, r.value_length, r.time_to_live);
      endfunction

      function void check_item(rsp_type got);
         rsp_type want;
         if (due_items.size() == 0) begin
            error_count++;
            if (error_count <= MAX_REPORTS)
               $display("unexpected result: %s", describe(got));
            return;
         end
         want = due_items.pop_front();
         if (got.item_kind !== want.item_kind || got.payload_byte !== want.payload_byte ||
             got.command_code !== want.command_code ||
             got.key_length !== want.key_length ||
             got.value_present !== want.value_present ||
             got.value_length !== want.value_length ||
             got.time_to_live !== want.time_to_live) begin
            error_count++;
            if (error_count <= MAX_REPORTS)
               $display("mismatch: expected %s\n          actual   %s",
                        describe(want), describe(got));
         end
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [7:0]  req_data_byte;
   logic        req_start_of_message;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [1:0]  rsp_item_kind;
   logic [7:0]  rsp_payload_byte;
   logic [2:0]  rsp_command_code;
   logic [7:0]  rsp_key_length;
   logic        rsp_value_present;
   logic [15:0] rsp_value_length;
   logic [31:0] rsp_time_to_live;

   frame_parse_tracker tracker;
   bit allow_idle;
   bit hold_ask;
   int hold_left;
   int bytes_sent;
   int request_count;
   int quiet_cycles;

   kv_request_frame_parser_core dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_data_byte        (req_data_byte),
      .req_start_of_message (req_start_of_message),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_item_kind        (rsp_item_kind),
      .rsp_payload_byte     (rsp_payload_byte),
      .rsp_command_code     (rsp_command_code),
      .rsp_key_length       (rsp_key_length),
      .rsp_value_present    (rsp_value_present),
      .rsp_value_length     (rsp_value_length),
      .rsp_time_to_live     (rsp_time_to_live)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready)
            tracker.check_item({rsp_item_kind, rsp_payload_byte, rsp_command_code,
                                rsp_key_length, rsp_value_present, rsp_value_length,
                                rsp_time_to_live});
         if (req_valid && req_ready)
            tracker.take_request_byte(req_data_byte, req_start_of_message);
      end
   end

   // receiver: random stalls, plus one long hold-off to back the block up
   always @(negedge clock) begin
      if (hold_ask) begin
         hold_ask = 1'b0;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= !(allow_idle && $urandom_range(0, 99) < 12);
      end
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("timeout: no handshake for %0d cycles", quiet_cycles);
         $display("FAILED: results differ");
         $finish;
      end
   end

   // called at a falling edge, returns at the falling edge after acceptance
   task automatic send_byte(input logic [7:0] b, input logic som);
      while (allow_idle && $urandom_range(0, 99) < 12) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data_byte <= b;
      req_start_of_message <= som;
      do @(posedge clock); while (!req_ready);
      bytes_sent++;
      @(negedge clock);
   endtask

   function automatic logic [7:0] field_byte();
      return ($urandom_range(0, 99) < 8) ? 8'd0 : 8'($urandom_range(1, 255));
   endfunction

   task automatic send_random_request(input int key_len_pick);
      logic [7:0]  frame[$];
      logic [7:0]  cmd_q[$];
      logic [47:0] word;
      logic [7:0]  flag;
      int          r;
      int          name_len;
      int          key_len;
      int          val_len;
      bit          cut_short;
      cut_short = 1'b0;
      case ($urandom_range(0, 3))
         0: begin word = "SET"; name_len = 3; end
         1: begin word = "GET"; name_len = 3; end
         2: begin word = "DELETE"; name_len = 6; end
         default: begin word = "EXPIRE"; name_len = 6; end
      endcase
      r = $urandom_range(0, 9);
      if (r <= 7)
         for (int j = 0; j < name_len; j++) cmd_q.push_back(word[8*(name_len-1-j) +: 8]);
      if (r == 6) begin
         // near miss: one byte changed, one short or one too long
         case ($urandom_range(0, 2))
            0: cmd_q[$urandom_range(0, name_len - 1)] = 8'($urandom_range(1, 255));
            1: cmd_q.delete(name_len - 1);
            default: cmd_q.push_back(8'($urandom_range(1, 255)));
         endcase
      end else if (r == 7) begin
         // a zero ends the name, so the trailer must not spoil the match
         cmd_q.push_back(8'd0);
         repeat ($urandom_range(0, 3)) cmd_q.push_back(8'($urandom_range(0, 255)));
      end else if (r == 8) begin
         repeat ($urandom_range(1, 9)) cmd_q.push_back(field_byte());
      end
      frame.push_back(8'(cmd_q.size()));
      foreach (cmd_q[j]) frame.push_back(cmd_q[j]);

      r = $urandom_range(0, 99);
      if (key_len_pick >= 0) key_len = key_len_pick;
      else if (r < 10) key_len = 0;
      else if (r < 96) key_len = $urandom_range(1, 8);
      else if (r < 99) key_len = $urandom_range(9, 60);
      else key_len = 255;
      frame.push_back(8'(key_len));
      repeat (key_len) frame.push_back(field_byte());

      flag = ($urandom_range(0, 99) < 70) ? 8'd1 : 8'($urandom_range(0, 255));
      frame.push_back(flag);
      if (flag == 8'd1) begin
         r = $urandom_range(0, 99);
         if (r < 4) begin
            // huge value length, abandoned by the next start
            frame.push_back(8'($urandom_range(128, 255)));
            frame.push_back(8'($urandom_range(0, 255)));
            repeat ($urandom_range(0, 5)) frame.push_back(field_byte());
            cut_short = 1'b1;
         end else begin
            if (r < 12) val_len = 0;
            else if (r < 88) val_len = $urandom_range(1, 8);
            else if (r < 97) val_len = $urandom_range(9, 40);
            else val_len = $urandom_range(256, 290);
            frame.push_back(val_len[15:8]);
            frame.push_back(val_len[7:0]);
            repeat (val_len) frame.push_back(field_byte());
         end
      end

      if (!cut_short) begin
         if ($urandom_range(0, 99) < 55) begin
            frame.push_back(8'd1);
            repeat (4) frame.push_back(8'($urandom_range(0, 255)));
         end else begin
            frame.push_back(8'($urandom_range(0, 255)));
         end
         if ($urandom_range(0, 99) < 6)
            repeat ($urandom_range(1, frame.size() - 1)) frame.delete(frame.size() - 1);
      end

      foreach (frame[j]) send_byte(frame[j], j == 0);
      // stray bytes after the summary are dropped until the next start
      if ($urandom_range(0, 99) < 10)
         repeat ($urandom_range(1, 3)) send_byte(8'($urandom_range(0, 255)), 1'b0);
   endtask

   initial begin
      tracker = new();
      reset = 1'b1;
      req_valid = 1'b0;
      req_data_byte = '0;
      req_start_of_message = 1'b0;
      rsp_ready = 1'b0;
      allow_idle = 1'b1;
      hold_ask = 1'b0;
      hold_left = 0;
      bytes_sent = 0;
      request_count = 0;
      quiet_cycles = 0;
      repeat (11) @(negedge clock);
      reset <= 1'b0;

      // first byte after reset counts as a command length without the start flag
      send_byte(8'd3, 1'b0);
      send_byte("G", 1'b0);
      send_byte("E", 1'b0);
      send_byte("T", 1'b0);
      send_byte(8'd1, 1'b0);
      send_byte("k", 1'b0);
      send_byte(8'd0, 1'b0);
      send_byte(8'd0, 1'b0);
      send_byte(8'h55, 1'b0);
      // request cut off by a new start
      send_byte(8'd6, 1'b1);
      send_byte("D", 1'b0);
      // empty command and key, odd value flag, largest ttl
      send_byte(8'd0, 1'b1);
      send_byte(8'd0, 1'b0);
      send_byte(8'd2, 1'b0);
      send_byte(8'd1, 1'b0);
      repeat (4) send_byte(8'hff, 1'b0);
      // value whose first byte is zero, so nothing of it is kept
      send_byte(8'd3, 1'b1);
      send_byte("S", 1'b0);
      send_byte("E", 1'b0);
      send_byte("T", 1'b0);
      send_byte(8'd2, 1'b0);
      send_byte(8'hff, 1'b0);
      send_byte(8'd0, 1'b0);
      send_byte(8'd1, 1'b0);
      send_byte(8'd0, 1'b0);
      send_byte(8'd2, 1'b0);
      send_byte(8'd0, 1'b0);
      send_byte(8'h7f, 1'b0);
      send_byte(8'd0, 1'b0);

      while (bytes_sent < BYTE_TARGET) begin
         allow_idle = !(request_count >= 8 && request_count < 16);
         if (request_count == 4) begin
            hold_ask = 1'b1;
            send_random_request(120);
         end else begin
            send_random_request(-1);
         end
         request_count++;
      end
      req_valid <= 1'b0;

      while (tracker.due_items.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      if (tracker.error_count == 0 && tracker.due_items.size() == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule

[kv_request_frame_parser_core.f]
sv/kvp_pkg.sv
sv/kvp_cmd_match.sv
sv/kvp_parser.sv
sv/kvp_rsp_reg.sv
sv/kv_request_frame_parser_core.sv
sv/kvp_checker.sv
tb/sv/tb_kv_request_frame_parser_core.sv
